FILE: hw/rtl/sfcd_pkg.sv
// shared types, constants and helpers for the sbus frame channel decoder
`timescale 1ns / 1ps
`default_nettype none
package sfcd_pkg;

	localparam int RX_BYTE_W     = 8;
	localparam int POS_W         = 5;
	localparam int NUM_CH        = 16;
	localparam int CH_NUM_W      = 4;
	localparam int CH_BITS       = 11;
	localparam int ADJ_W         = 12;
	localparam int STATUS_W      = 2;
	localparam int STREAM_BITS   = 176;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [RX_BYTE_W-1:0] START_BYTE    = 8'hF0;
	localparam logic [RX_BYTE_W-1:0] FLAG_LOST     = 8'h20;
	localparam logic [RX_BYTE_W-1:0] FLAG_FAILSAFE = 8'h30;
	localparam logic [POS_W-1:0]     PAYLOAD_FIRST = 5'd1;
	localparam logic [POS_W-1:0]     PAYLOAD_LAST  = 5'd22;
	localparam logic [POS_W-1:0]     FLAG_POS      = 5'd23;
	localparam logic [POS_W-1:0]     POS_LIMIT     = 5'd25;
	localparam logic [ADJ_W-1:0]     ADJ_OFFSET    = 12'd875;

	typedef enum logic [STATUS_W-1:0] {
		LINK_NORMAL   = 2'd0,
		LINK_LOST     = 2'd1,
		LINK_FAILSAFE = 2'd2
	} link_status_t;

	typedef struct packed {
		logic [STREAM_BITS-1:0] stream;
		link_status_t           status;
	} frame_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} back_state_t;

	// first received bit of a byte lands on the lowest stream bit
	function automatic logic [RX_BYTE_W-1:0] bit_reverse(input logic [RX_BYTE_W-1:0] b);
		logic [RX_BYTE_W-1:0] r;
		for (int i = 0; i < RX_BYTE_W; i++) begin
			r[i] = b[RX_BYTE_W-1-i];
		end
		return r;
	endfunction

	function automatic link_status_t flag_to_status(input logic [RX_BYTE_W-1:0] f);
		link_status_t s;
		s = LINK_NORMAL;
		if (f == FLAG_LOST) begin
			s = LINK_LOST;
		end else if (f == FLAG_FAILSAFE) begin
			s = LINK_FAILSAFE;
		end
		return s;
	endfunction

	// v*10/16 + offset, the multiply done as two shifts and an add
	function automatic logic [ADJ_W-1:0] adjust(input logic [CH_BITS-1:0] v);
		logic [CH_BITS+3:0] t;
		t = ({4'b0, v} << 3) + ({4'b0, v} << 1);
		return {1'b0, t[CH_BITS+3:4]} + ADJ_OFFSET;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/sfcd_if.sv
// handshake channels: received bytes in, channel results out
`timescale 1ns / 1ps
`default_nettype none
interface sfcd_in_if;
	import sfcd_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [RX_BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfcd_out_if;
	import sfcd_pkg::*;

	logic                valid;
	logic                ready;
	logic [CH_NUM_W-1:0] channel_number;
	logic [CH_BITS-1:0]  channel_value;
	logic [ADJ_W-1:0]    adjusted_value;
	logic [STATUS_W-1:0] link_status;
	logic                last_channel;

	modport source (output valid, output channel_number, output channel_value,
		output adjusted_value, output link_status, output last_channel, input ready);
	modport sink (input valid, input channel_number, input channel_value,
		input adjusted_value, input link_status, input last_channel, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/sfcd_front.sv
// front end: tracks byte position, collects payload bits, hands off complete frames
`timescale 1ns / 1ps
`default_nettype none
module sfcd_front (
	input  wire                 clk,
	input  wire                 arst_n,
	sfcd_in_if.sink             frame,
	input  sfcd_pkg::queue_stat_t qstat,
	output logic                push,
	output sfcd_pkg::frame_t    push_frame
);
	import sfcd_pkg::*;

	logic [POS_W-1:0]       pos_q;
	logic [POS_W-1:0]       pos_eff;
	logic [STREAM_BITS-1:0] stream_q;
	logic                   accept;

	assign frame.ready = !qstat.full;
	assign accept      = frame.valid && frame.ready;
	assign pos_eff     = (frame.rx_byte == START_BYTE) ? '0 : pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= (pos_eff == POS_LIMIT) ? POS_LIMIT : pos_eff + 1'b1;
		end
	end

	// payload bytes shift in from the top, so byte 1 ends up at the low end
	always_ff @(posedge clk) begin
		if (accept && pos_eff >= PAYLOAD_FIRST && pos_eff <= PAYLOAD_LAST) begin
			stream_q <= {bit_reverse(frame.rx_byte), stream_q[STREAM_BITS-1:RX_BYTE_W]};
		end
	end

	assign push              = accept && (pos_eff == FLAG_POS);
	assign push_frame.stream = stream_q;
	assign push_frame.status = flag_to_status(frame.rx_byte);

endmodule
`default_nettype wire

FILE: hw/rtl/sfcd_queue.sv
// short frame queue between front and back end
`timescale 1ns / 1ps
`default_nettype none
module sfcd_queue #(
	parameter int DEPTH = sfcd_pkg::QUEUE_DEPTH
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  sfcd_pkg::frame_t      push_frame,
	input  wire                   pop,
	output sfcd_pkg::frame_t      head,
	output sfcd_pkg::queue_stat_t qstat
);
	import sfcd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	frame_t             entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign qstat.full  = (count_q == CNT_W'(DEPTH));
	assign qstat.empty = (count_q == '0);
	assign head        = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_frame;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/sfcd_back.sv
// back end: unpacks a queued frame to output register, one channel per unstalled cycle
`timescale 1ns / 1ps
`default_nettype none
module sfcd_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  sfcd_pkg::frame_t      head,
	input  sfcd_pkg::queue_stat_t qstat,
	output logic                  pop,
	sfcd_out_if.source            channel
);
	import sfcd_pkg::*;

	back_state_t            state_q;
	back_state_t            state_d;
	logic [STREAM_BITS-1:0] work_q;
	link_status_t           status_q;
	logic [CH_NUM_W-1:0]    ch_q;
	logic                   emit;
	logic                   last;
	logic                   out_valid_q;
	logic [CH_NUM_W-1:0]    out_num_q;
	logic [CH_BITS-1:0]     out_val_q;
	logic [ADJ_W-1:0]       out_adj_q;
	link_status_t           out_status_q;
	logic                   out_last_q;

	assign last = (ch_q == CH_NUM_W'(NUM_CH - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!qstat.empty) begin
					state_d = BK_RUN;
				end
			end
			BK_RUN: begin
				if (emit && last) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop  = 1'b0;
		emit = 1'b0;
		unique case (state_q)
			BK_IDLE: pop  = !qstat.empty;
			BK_RUN:  emit = !out_valid_q || channel.ready;
			default: begin
				pop  = 1'b0;
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				ch_q <= '0;
			end else if (emit) begin
				ch_q <= ch_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (channel.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// channel bits sit at the low end of the work word, next channel after a shift
	always_ff @(posedge clk) begin
		if (pop) begin
			work_q   <= head.stream;
			status_q <= head.status;
		end else if (emit) begin
			work_q <= work_q >> CH_BITS;
		end
		if (emit) begin
			out_num_q    <= ch_q;
			out_val_q    <= work_q[CH_BITS-1:0];
			out_adj_q    <= adjust(work_q[CH_BITS-1:0]);
			out_status_q <= status_q;
			out_last_q   <= last;
		end
	end

	assign channel.valid          = out_valid_q;
	assign channel.channel_number = out_num_q;
	assign channel.channel_value  = out_val_q;
	assign channel.adjusted_value = out_adj_q;
	assign channel.link_status    = out_status_q;
	assign channel.last_channel   = out_last_q;

endmodule
`default_nettype wire

FILE: hw/rtl/sbus_frame_channel_decoder_unit.sv
// top level of the sbus frame channel decoder
//
//  port     dir   word                      notes
//  frame    in    rx_byte (8)               one received frame byte, first bit at bit 7
//  channel  out   number, value, adjusted,  sixteen words per frame, last_channel on
//                 link status, last         the sixteenth
//
// the flag byte queues a whole frame for the back end
// the back end loads a frame while idle, then emits its sixteen channels one at a time,
// holding a channel while the output side stalls
// reset clears byte position, queue pointers and output valid; no clearing pass
// bytes stall only while the frame queue is full; output stalls hold the back end
`timescale 1ns / 1ps
`default_nettype none
module sbus_frame_channel_decoder_unit #(
	parameter int QUEUE_DEPTH = sfcd_pkg::QUEUE_DEPTH
) (
	input  wire         clk,
	input  wire         arst_n,
	sfcd_in_if.sink     frame,
	sfcd_out_if.source  channel
);
	import sfcd_pkg::*;

	queue_stat_t qstat;
	logic        push;
	frame_t      push_frame;
	logic        pop;
	frame_t      head;

	sfcd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame      (frame),
		.qstat      (qstat),
		.push       (push),
		.push_frame (push_frame)
	);

	sfcd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	sfcd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.qstat   (qstat),
		.pop     (pop),
		.channel (channel)
	);

endmodule
`default_nettype wire
